>>> hw/rtl/pidac_pkg.sv
// Shared types, constants and helpers of the per-axis PID controller.
package pidac_pkg;

    localparam int AXES_DEF   = 3;
    localparam int GAIN_SLOTS = 3;
    localparam int AXIS_W     = 2;
    localparam int ERR_W      = 20;
    localparam int GAIN_W     = 16;
    localparam int DRIVE_W    = 15;
    localparam int INT_W      = 32;
    localparam int LAST_W     = 16;
    localparam int OLIM_W     = 14;
    localparam int LP_W       = 24;
    localparam int CFG_W      = 48;
    localparam int PDATA_W    = 64;
    localparam int PADDR_W    = 6;
    localparam int REG_LSB    = 3;

    localparam logic [OLIM_W-1:0] DRIVE_MAX = 14'd16383;

    // Shared multiplier and internal widths.
    localparam int MUL_A_W = 40;
    localparam int MUL_B_W = 17;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;
    localparam int S_W     = 23;
    localparam int ACC_W   = 43;
    localparam int SUM_W   = 56;
    localparam int PROD_W  = 64;

    // Constant divider: a few quotient bits per cycle, narrow remainder.
    localparam int DIV_W     = 44;
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = DIV_W / DIV_BITS;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);
    localparam int REM_W     = 6;

    localparam logic [REM_W-1:0] DECAY_DEN = 6'd50;
    localparam logic [REM_W-1:0] INC_DEN   = 6'd6;
    localparam logic [6:0]       DECAY_NUM = 7'd49;

    localparam int LP_SPLIT   = 12;
    localparam int INC_SHIFT  = 20;
    localparam int ILIM_SHIFT = 14;
    localparam int P_SHIFT    = 13;
    localparam int I_SHIFT    = 9;
    localparam int OUT_SHIFT  = 23;

    localparam logic [CFG_W-1:0] KP_RST   = 48'd8796117205361;
    localparam logic [CFG_W-1:0] KI_RST   = 48'd5278675896730;
    localparam logic [CFG_W-1:0] KD_RST   = 48'd161089946;
    localparam logic [CFG_W-1:0] OLIM_RST = 48'd35185231082291;
    localparam logic [CFG_W-1:0] ILIM_RST = 48'd35185231082291;
    localparam logic [LP_W-1:0]  LP_RST   = 24'd16777;
    localparam logic [15:0]      DTF_RST  = 16'd13107;

    typedef enum logic [2:0] {
        REG_KP, REG_KI, REG_KD, REG_OLIM, REG_ILIM, REG_LP, REG_DTF
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] kp;
        logic [CFG_W-1:0] ki;
        logic [CFG_W-1:0] kd;
        logic [CFG_W-1:0] olim;
        logic [CFG_W-1:0] ilim;
        logic [LP_W-1:0]  lp;
        logic [15:0]      dtf;
    } cfg_t;

    typedef enum logic [3:0] {
        S_IDLE, S_PREP, S_DEC_DIV, S_DEC_END, S_MUL_SK, S_MUL_LO, S_MUL_HI,
        S_INC_START, S_INC_DIV, S_INC_END, S_MUL_P, S_MUL_D1, S_MUL_D2,
        S_SUM, S_FINISH
    } ctl_state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_DECAY_START, OP_DIV_STEP, OP_DECAY_END,
        OP_MUL_SK, OP_MUL_LO, OP_MUL_HI, OP_INC_START, OP_INC_END,
        OP_MUL_P, OP_MUL_D1, OP_MUL_D2, OP_SUM, OP_FINISH
    } op_t;

    typedef struct packed {
        logic axis_ok;
        logic ground;
        logic hold;
        logic div_last;
        logic out_full;
    } status_t;

    function automatic logic [GAIN_W-1:0] slot16(input logic [CFG_W-1:0] r,
                                                 input logic [AXIS_W-1:0] a);
        logic [CFG_W-1:0] sh;
        sh = r >> (GAIN_W * int'(a));
        return sh[GAIN_W-1:0];
    endfunction

endpackage

>>> hw/rtl/pidac_if.sv
// Valid/ready channel interfaces for the sample and result words.
interface pidac_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         axis;
    logic signed [19:0] rate_error;
    logic signed [19:0] gyro_rate;
    logic               on_ground;

    modport source (output valid, axis, rate_error, gyro_rate, on_ground, input ready);
    modport sink (input valid, axis, rate_error, gyro_rate, on_ground, output ready);
endinterface

interface pidac_out_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] drive;
    logic [1:0]         axis_out;
    logic               windup_hold;

    modport source (output valid, drive, axis_out, windup_hold, input ready);
    modport sink (input valid, drive, axis_out, windup_hold, output ready);
endinterface

>>> hw/rtl/pidac_ctrl.sv
// Sequencer that steps the PID datapath through one sample.
module pidac_ctrl
    import pidac_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output op_t     op
);

    ctl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                if (!status.axis_ok)
                begin
                    state_next = S_FINISH;
                end
                else if (status.ground)
                begin
                    state_next = S_DEC_DIV;
                end
                else if (status.hold)
                begin
                    state_next = S_INC_END;
                end
                else
                begin
                    state_next = S_MUL_SK;
                end
            end
            S_DEC_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = S_DEC_END;
                end
            end
            S_DEC_END:   state_next = status.hold ? S_INC_END : S_MUL_SK;
            S_MUL_SK:    state_next = S_MUL_LO;
            S_MUL_LO:    state_next = S_MUL_HI;
            S_MUL_HI:    state_next = S_INC_START;
            S_INC_START: state_next = S_INC_DIV;
            S_INC_DIV:
            begin
                if (status.div_last)
                begin
                    state_next = S_INC_END;
                end
            end
            S_INC_END:   state_next = S_MUL_P;
            S_MUL_P:     state_next = S_MUL_D1;
            S_MUL_D1:    state_next = S_MUL_D2;
            S_MUL_D2:    state_next = S_SUM;
            S_SUM:       state_next = S_FINISH;
            S_FINISH:
            begin
                if (!status.out_full)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        op       = OP_NONE;
        in_ready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    op = OP_LOAD;
                end
            end
            S_PREP:
            begin
                if (status.axis_ok && status.ground)
                begin
                    op = OP_DECAY_START;
                end
            end
            S_DEC_DIV:   op = OP_DIV_STEP;
            S_DEC_END:   op = OP_DECAY_END;
            S_MUL_SK:    op = OP_MUL_SK;
            S_MUL_LO:    op = OP_MUL_LO;
            S_MUL_HI:    op = OP_MUL_HI;
            S_INC_START: op = OP_INC_START;
            S_INC_DIV:   op = OP_DIV_STEP;
            S_INC_END:   op = OP_INC_END;
            S_MUL_P:     op = OP_MUL_P;
            S_MUL_D1:    op = OP_MUL_D1;
            S_MUL_D2:    op = OP_MUL_D2;
            S_SUM:       op = OP_SUM;
            S_FINISH:
            begin
                if (!status.out_full)
                begin
                    op = OP_FINISH;
                end
            end
            default:     op = OP_NONE;
        endcase
    end

endmodule

>>> hw/rtl/pidac_datapath.sv
// PID datapath: per-axis history, shared multiplier, constant divider, output register.
module pidac_datapath
    import pidac_pkg::*;
#(
    parameter int AXES = AXES_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  op_t                       op,
    input  cfg_t                      cfg,
    input  logic [AXIS_W-1:0]         axis,
    input  logic signed [ERR_W-1:0]   rate_error,
    input  logic signed [ERR_W-1:0]   gyro_rate,
    input  logic                      on_ground,
    input  logic                      out_ready,
    output status_t                   status,
    output logic                      out_valid,
    output logic signed [DRIVE_W-1:0] drive,
    output logic [AXIS_W-1:0]         axis_out,
    output logic                      windup_hold
);

    localparam int AW = (AXES > 1) ? $clog2(AXES) : 1;

    // Per-axis state.
    logic signed [INT_W-1:0]  integral_reg [AXES];
    logic signed [ERR_W-1:0]  e1_mem_reg   [AXES];
    logic signed [ERR_W-1:0]  e2_mem_reg   [AXES];
    logic signed [ERR_W-1:0]  g1_mem_reg   [AXES];
    logic signed [ERR_W-1:0]  g2_mem_reg   [AXES];
    logic signed [LAST_W-1:0] last_reg     [AXES];

    // Working registers of the current sample.
    logic [AXIS_W-1:0]        axis_reg;
    logic                     ok_reg, ground_reg, hold_reg;
    logic signed [ERR_W-1:0]  e_reg, g_reg, e1_reg, e2_reg, g1_reg, g2_reg;
    logic [GAIN_W-1:0]        kp_reg, ki_reg, kd_reg, ilim_reg;
    logic [OLIM_W-1:0]        olim_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [MUL_A_W-1:0] p1_reg;
    logic signed [MUL_P_W-1:0] lo_reg, hi_reg;
    logic signed [MUL_A_W-1:0] pterm_reg, d1_reg;
    logic signed [MUL_P_W-1:0] dterm_reg;
    logic signed [SUM_W-1:0]  sum_reg;

    // Divider registers.
    logic [DIV_W-1:0]     div_q_reg;
    logic [REM_W-1:0]     div_rem_reg, div_d_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic                 div_neg_reg;

    // Output register.
    logic                      out_valid_reg;
    logic signed [DRIVE_W-1:0] drive_reg;
    logic [AXIS_W-1:0]         axis_out_reg;
    logic                      hold_out_reg;

    // Load-time view of the addressed axis.
    logic [AW-1:0]            in_idx, idx;
    logic                     in_ok;
    logic [GAIN_W-1:0]        olim_raw;
    logic [OLIM_W-1:0]        olim_in;
    logic signed [LAST_W:0]   last_in, olim_pos;
    logic                     hold_in;

    assign in_idx   = AW'(axis);
    assign idx      = AW'(axis_reg);
    assign in_ok    = (32'(axis) < 32'(AXES)) && (32'(axis) < 32'(GAIN_SLOTS));
    assign olim_raw = slot16(cfg.olim, axis);
    assign olim_in  = (olim_raw > GAIN_W'(DRIVE_MAX)) ? DRIVE_MAX : olim_raw[OLIM_W-1:0];
    assign last_in  = in_ok ? (LAST_W + 1)'(last_reg[in_idx]) : '0;
    assign olim_pos = $signed({3'b000, olim_in});
    assign hold_in  = in_ok && (((last_in == olim_pos) && (rate_error > 0)) ||
                                ((last_in == -olim_pos) && (rate_error < 0)));

    // Shared multiplier operands.
    logic signed [S_W-1:0]     s_sum;
    logic signed [ERR_W:0]     g_diff;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;

    assign s_sum  = S_W'(e2_reg) + (S_W'(e1_reg) <<< 2) + S_W'(e_reg);
    assign g_diff = (ERR_W + 1)'(g_reg) - (ERR_W + 1)'(g2_reg);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (op)
            OP_MUL_SK:
            begin
                mul_a = MUL_A_W'(s_sum);
                mul_b = $signed({1'b0, ki_reg});
            end
            OP_MUL_LO:
            begin
                mul_a = p1_reg;
                mul_b = $signed(MUL_B_W'(cfg.lp[LP_SPLIT-1:0]));
            end
            OP_MUL_HI:
            begin
                mul_a = p1_reg;
                mul_b = $signed(MUL_B_W'(cfg.lp[LP_W-1:LP_SPLIT]));
            end
            OP_MUL_P:
            begin
                mul_a = MUL_A_W'(e_reg);
                mul_b = $signed({1'b0, kp_reg});
            end
            OP_MUL_D1:
            begin
                mul_a = MUL_A_W'(g_diff);
                mul_b = $signed({1'b0, kd_reg});
            end
            OP_MUL_D2:
            begin
                mul_a = d1_reg;
                mul_b = $signed({1'b0, cfg.dtf});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Divider: DIV_BITS restoring steps per cycle on a remainder below the divisor.
    logic [DIV_W-1:0] step_q;
    logic [REM_W-1:0] step_rem;
    logic [REM_W:0]   trial;

    always_comb
    begin
        step_q   = div_q_reg;
        step_rem = div_rem_reg;
        trial    = '0;
        for (int i = 0; i < DIV_BITS; i++)
        begin
            trial  = {step_rem, step_q[DIV_W-1]};
            step_q = step_q << 1;
            if (trial >= {1'b0, div_d_reg})
            begin
                trial     = trial - {1'b0, div_d_reg};
                step_q[0] = 1'b1;
            end
            step_rem = trial[REM_W-1:0];
        end
    end

    // Signed quotient, decay dividend and integral increment dividend.
    logic signed [ACC_W-1:0]  q_mag, q_signed;
    logic signed [ACC_W-1:0]  acc_abs;
    logic signed [PROD_W-1:0] prod, prod_abs;

    assign q_mag    = $signed(ACC_W'(div_q_reg));
    assign q_signed = div_neg_reg ? -q_mag : q_mag;
    assign acc_abs  = (acc_reg < 0) ? -acc_reg : acc_reg;
    assign prod     = PROD_W'(lo_reg) + (PROD_W'(hi_reg) <<< LP_SPLIT);
    assign prod_abs = (prod < 0) ? -prod : prod;

    // Integral update and clamp.
    logic signed [ACC_W-1:0] acc_sum, ilim_pos, acc_clamp;

    assign acc_sum  = acc_reg + (hold_reg ? '0 : q_signed);
    assign ilim_pos = $signed(ACC_W'({ilim_reg, {ILIM_SHIFT{1'b0}}}));
    assign acc_clamp = (acc_sum > ilim_pos) ? ilim_pos :
                       (acc_sum < -ilim_pos) ? -ilim_pos : acc_sum;

    // Output clamp; the arithmetic shift rounds toward minus infinity.
    logic signed [SUM_W-1:0]   olim_sum, sum_clamp, sum_shift;
    logic signed [DRIVE_W-1:0] drive_new;

    assign olim_sum  = $signed(SUM_W'({olim_reg, {OUT_SHIFT{1'b0}}}));
    assign sum_clamp = (sum_reg > olim_sum) ? olim_sum :
                       (sum_reg < -olim_sum) ? -olim_sum : sum_reg;
    assign sum_shift = sum_clamp >>> OUT_SHIFT;
    assign drive_new = ok_reg ? DRIVE_W'(sum_shift) : '0;

    // Payload registers.
    always_ff @(posedge clk)
    begin
        case (op)
            OP_LOAD:
            begin
                axis_reg   <= axis;
                ok_reg     <= in_ok;
                ground_reg <= on_ground;
                hold_reg   <= hold_in;
                e_reg      <= rate_error;
                g_reg      <= gyro_rate;
                e1_reg     <= in_ok ? e1_mem_reg[in_idx] : '0;
                e2_reg     <= in_ok ? e2_mem_reg[in_idx] : '0;
                g1_reg     <= in_ok ? g1_mem_reg[in_idx] : '0;
                g2_reg     <= in_ok ? g2_mem_reg[in_idx] : '0;
                acc_reg    <= in_ok ? ACC_W'(integral_reg[in_idx]) : '0;
                kp_reg     <= slot16(cfg.kp, axis);
                ki_reg     <= slot16(cfg.ki, axis);
                kd_reg     <= slot16(cfg.kd, axis);
                ilim_reg   <= slot16(cfg.ilim, axis);
                olim_reg   <= olim_in;
            end
            OP_DECAY_START:
            begin
                div_q_reg   <= DIV_W'(acc_abs) * DIV_W'(DECAY_NUM);
                div_neg_reg <= acc_reg < 0;
                div_d_reg   <= DECAY_DEN;
                div_rem_reg <= '0;
            end
            OP_DIV_STEP:
            begin
                div_q_reg   <= step_q;
                div_rem_reg <= step_rem;
            end
            OP_DECAY_END: acc_reg <= q_signed;
            OP_MUL_SK:    p1_reg  <= MUL_A_W'(mul_p);
            OP_MUL_LO:    lo_reg  <= mul_p;
            OP_MUL_HI:    hi_reg  <= mul_p;
            OP_INC_START:
            begin
                div_q_reg   <= DIV_W'(prod_abs >>> INC_SHIFT);
                div_neg_reg <= prod < 0;
                div_d_reg   <= INC_DEN;
                div_rem_reg <= '0;
            end
            OP_INC_END:   acc_reg   <= acc_clamp;
            OP_MUL_P:     pterm_reg <= MUL_A_W'(mul_p);
            OP_MUL_D1:    d1_reg    <= MUL_A_W'(mul_p);
            OP_MUL_D2:    dterm_reg <= mul_p;
            OP_SUM:
            begin
                sum_reg <= (SUM_W'(pterm_reg) <<< P_SHIFT)
                         + (SUM_W'(acc_reg) <<< I_SHIFT)
                         - SUM_W'(dterm_reg);
            end
            OP_FINISH:
            begin
                drive_reg    <= drive_new;
                axis_out_reg <= axis_reg;
                hold_out_reg <= ok_reg && hold_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Divider step count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (op == OP_DECAY_START || op == OP_INC_START)
        begin
            div_cnt_reg <= '0;
        end
        else if (op == OP_DIV_STEP)
        begin
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    // Per-axis history, written back when a sample finishes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                integral_reg[a] <= '0;
                e1_mem_reg[a]   <= '0;
                e2_mem_reg[a]   <= '0;
                g1_mem_reg[a]   <= '0;
                g2_mem_reg[a]   <= '0;
                last_reg[a]     <= '0;
            end
        end
        else if (op == OP_FINISH && ok_reg)
        begin
            integral_reg[idx] <= INT_W'(acc_reg);
            g2_mem_reg[idx]   <= g1_reg;
            g1_mem_reg[idx]   <= g_reg;
            last_reg[idx]     <= LAST_W'(drive_new);
            if (!hold_reg)
            begin
                e2_mem_reg[idx] <= e1_reg;
                e1_mem_reg[idx] <= e_reg;
            end
        end
    end

    // Output word handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (op == OP_FINISH)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.axis_ok  = ok_reg;
    assign status.ground   = ground_reg;
    assign status.hold     = hold_reg;
    assign status.div_last = div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1);
    assign status.out_full = out_valid_reg && !out_ready;

    assign out_valid   = out_valid_reg;
    assign drive       = drive_reg;
    assign axis_out    = axis_out_reg;
    assign windup_hold = hold_out_reg;

endmodule

>>> hw/rtl/pid_axis_controller.sv
// Top level of the three-axis PID controller: register port, sequencer and datapath.
//
// One sample word is taken at a time and yields one result word. When on_ground is
// set the integral decays first; when anti-windup holds the integral, the increment is
// skipped; a sample with an axis out of range goes straight to the result register. The
// time a sample takes is set by the constant divider, which produces four quotient bits
// per cycle for the decay and again for the Simpson increment, and by the single shared
// multiplier that forms the six products in turn.
// A finished word sits in the output register while the next sample is accepted.
// Registers lie at byte address 8*i on the 64-bit configuration port; write them only
// while the block is idle.
module pid_axis_controller
    import pidac_pkg::*;
#(
    parameter int AXES = AXES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    pidac_in_if.sink           sample,
    pidac_out_if.source        result,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [CFG_W-1:0] kp_reg, ki_reg, kd_reg, olim_reg, ilim_reg;
    logic [LP_W-1:0]  lp_reg;
    logic [15:0]      dtf_reg;
    reg_idx_t         reg_idx;
    logic             wr_en;
    cfg_t             cfg;
    status_t          status;
    op_t              op;

    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[PADDR_W-1:REG_LSB]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg   <= KP_RST;
            ki_reg   <= KI_RST;
            kd_reg   <= KD_RST;
            olim_reg <= OLIM_RST;
            ilim_reg <= ILIM_RST;
            lp_reg   <= LP_RST;
            dtf_reg  <= DTF_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_KP:   kp_reg   <= pwdata[CFG_W-1:0];
                REG_KI:   ki_reg   <= pwdata[CFG_W-1:0];
                REG_KD:   kd_reg   <= pwdata[CFG_W-1:0];
                REG_OLIM: olim_reg <= pwdata[CFG_W-1:0];
                REG_ILIM: ilim_reg <= pwdata[CFG_W-1:0];
                REG_LP:   lp_reg   <= pwdata[LP_W-1:0];
                REG_DTF:  dtf_reg  <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_KP:   prdata = PDATA_W'(kp_reg);
            REG_KI:   prdata = PDATA_W'(ki_reg);
            REG_KD:   prdata = PDATA_W'(kd_reg);
            REG_OLIM: prdata = PDATA_W'(olim_reg);
            REG_ILIM: prdata = PDATA_W'(ilim_reg);
            REG_LP:   prdata = PDATA_W'(lp_reg);
            REG_DTF:  prdata = PDATA_W'(dtf_reg);
            default:  prdata = '0;
        endcase
    end

    assign cfg.kp   = kp_reg;
    assign cfg.ki   = ki_reg;
    assign cfg.kd   = kd_reg;
    assign cfg.olim = olim_reg;
    assign cfg.ilim = ilim_reg;
    assign cfg.lp   = lp_reg;
    assign cfg.dtf  = dtf_reg;

    pidac_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (sample.ready),
        .status   (status),
        .op       (op)
    );

    pidac_datapath #(
        .AXES (AXES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .cfg         (cfg),
        .axis        (sample.axis),
        .rate_error  (sample.rate_error),
        .gyro_rate   (sample.gyro_rate),
        .on_ground   (sample.on_ground),
        .out_ready   (result.ready),
        .status      (status),
        .out_valid   (result.valid),
        .drive       (result.drive),
        .axis_out    (result.axis_out),
        .windup_hold (result.windup_hold)
    );

endmodule

>>> dv/tb_pid_axis_controller.sv
// Self-checking testbench of the three-axis PID controller with its own rate-loop predictor.
module tb_pid_axis_controller;
    import pidac_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_WORDS   = 790;

    typedef struct packed {
        logic [1:0]         axis;
        logic signed [19:0] err;
        logic signed [19:0] gyro;
        logic               ground;
    } sample_t;

    typedef struct packed {
        logic signed [14:0] drive;
        logic [1:0]         axis;
        logic               hold;
    } drive_t;

    // One row of the directed table; chk says whether exp is typed in by hand.
    typedef struct packed {
        sample_t s;
        logic    chk;
        drive_t  exp;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    pidac_in_if  smp_ch ();
    pidac_out_if res_ch ();

    pid_axis_controller dut (
        .clk(clk), .rst_n(rst_n), .sample(smp_ch.sink), .result(res_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predictor copy of the register file and the per-axis loop state.
    logic [CFG_W-1:0] cfg_reg [7];
    longint integ [3];
    longint e1 [3];
    longint e2 [3];
    longint g1 [3];
    longint g2 [3];
    longint last_out [3];

    drive_t expected_drives [$];
    int mismatches = 0;
    int idle_cycles = 0;
    bit timed_out = 1'b0;
    int src_gap = 0;
    int snk_gap = 0;

    function automatic longint sat(longint v, longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic longint gain(reg_idx_t r, int a);
        return longint'((cfg_reg[r] >> (16 * a)) & 48'hFFFF);
    endfunction

    function automatic drive_t pid_step(sample_t s);
        drive_t r;
        int a;
        longint e, g, kp, ki, kd, olim, ilim, acc, sum, d;
        bit hold;
        a = s.axis;
        r.axis = s.axis;
        r.drive = '0;
        r.hold = 1'b0;
        if (a >= AXES_DEF) return r;
        e = s.err;
        g = s.gyro;
        kp = gain(REG_KP, a);
        ki = gain(REG_KI, a);
        kd = gain(REG_KD, a);
        olim = gain(REG_OLIM, a);
        if (olim > 16383) olim = 16383;
        ilim = gain(REG_ILIM, a);
        acc = integ[a];
        if (s.ground) acc = acc * 49 / 50;
        hold = (last_out[a] == olim && e > 0) || (last_out[a] == -olim && e < 0);
        if (!hold)
        begin
            acc += (e2[a] + 4 * e1[a] + e) * ki * longint'(cfg_reg[REG_LP]) / (6 * 1048576);
            e2[a] = e1[a];
            e1[a] = e;
        end
        acc = sat(acc, ilim * 16384);
        integ[a] = acc;
        sum = e * kp * 8192 + acc * 512 - (g - g2[a]) * kd * longint'(cfg_reg[REG_DTF]);
        g2[a] = g1[a];
        g1[a] = g;
        sum = sat(sum, olim * 8388608);
        // Shift down rounding toward minus infinity.
        d = (sum >= 0) ? sum / 8388608 : -((-sum + 8388607) / 8388608);
        last_out[a] = d;
        r.drive = d[14:0];
        r.hold = hold;
        return r;
    endfunction

    task automatic reg_write(reg_idx_t idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= PADDR_W'(int'(idx) * 8);
        pwdata <= PDATA_W'(val);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_LP) cfg_reg[idx] = val & 48'hFFFFFF;
        else if (idx == REG_DTF) cfg_reg[idx] = val & 48'hFFFF;
        else cfg_reg[idx] = val;
    endtask

    task automatic wait_drained();
        smp_ch.valid <= 1'b0;
        while (expected_drives.size() != 0) @(negedge clk);
        // Let the datapath go quiet before touching registers.
        repeat (40) @(negedge clk);
    endtask

    // The word stays valid after acceptance until the next send or a drain
    // replaces it at the following falling edge.
    task automatic send(sample_t s, drive_t exp_val, bit hand);
        drive_t p;
        while (src_gap != 0 && $urandom_range(99) < src_gap)
        begin
            smp_ch.valid <= 1'b0;
            @(negedge clk);
        end
        smp_ch.valid <= 1'b1;
        smp_ch.axis <= s.axis;
        smp_ch.rate_error <= s.err;
        smp_ch.gyro_rate <= s.gyro;
        smp_ch.on_ground <= s.ground;
        @(posedge clk);
        while (!smp_ch.ready) @(posedge clk);
        p = pid_step(s);
        if (hand && p != exp_val && mismatches < 10)
            $display("table row disagrees with predictor: %p vs %p", exp_val, p);
        if (hand && p != exp_val) mismatches++;
        expected_drives.push_back(p);
        @(negedge clk);
    endtask

    function automatic sample_t rnd_sample();
        sample_t s;
        int k;
        s.axis = ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2));
        k = $urandom_range(9);
        s.err = (k < 6) ? 20'($signed($urandom_range(8000)) - 4000) : 20'($urandom);
        s.gyro = (k < 7) ? 20'($signed($urandom_range(16000)) - 8000) : 20'($urandom);
        s.ground = ($urandom_range(7) == 0);
        return s;
    endfunction

    // Result checker and stall generator.
    always @(posedge clk)
    begin
        drive_t got;
        drive_t want;
        if (res_ch.valid && res_ch.ready)
        begin
            got.drive = res_ch.drive;
            got.axis = res_ch.axis_out;
            got.hold = res_ch.windup_hold;
            if (expected_drives.size() == 0)
            begin
                if (mismatches < 10) $display("unexpected word: %p", got);
                mismatches++;
            end
            else
            begin
                want = expected_drives.pop_front();
                if (got != want)
                begin
                    if (mismatches < 10)
                        $display("drive mismatch: expected %p got %p", want, got);
                    mismatches++;
                end
            end
        end
        if ((res_ch.valid && res_ch.ready) || (smp_ch.valid && smp_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(negedge clk)
        res_ch.ready <= !(snk_gap != 0 && $urandom_range(99) < snk_gap);

    initial
    begin
        row_t tbl [$];
        drive_t none;
        int i;
        smp_ch.valid = 1'b0;
        smp_ch.axis = '0;
        smp_ch.rate_error = '0;
        smp_ch.gyro_rate = '0;
        smp_ch.on_ground = 1'b0;
        res_ch.ready = 1'b0;
        none = '0;
        cfg_reg[REG_KP] = KP_RST;
        cfg_reg[REG_KI] = KI_RST;
        cfg_reg[REG_KD] = KD_RST;
        cfg_reg[REG_OLIM] = OLIM_RST;
        cfg_reg[REG_ILIM] = ILIM_RST;
        cfg_reg[REG_LP] = 48'(LP_RST);
        cfg_reg[REG_DTF] = 48'(DTF_RST);
        for (i = 0; i < 3; i++)
        begin
            integ[i] = 0; e1[i] = 0; e2[i] = 0; g1[i] = 0; g2[i] = 0; last_out[i] = 0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed rows: zero after reset, out-of-range axis, full-scale inputs.
        tbl.push_back('{s: '{2'd0, 20'sd0, 20'sd0, 1'b0}, chk: 1'b1, exp: '{15'sd0, 2'd0, 1'b0}});
        tbl.push_back('{s: '{2'd3, 20'h7FFFF, 20'h80000, 1'b1}, chk: 1'b1,
                        exp: '{15'sd0, 2'd3, 1'b0}});
        tbl.push_back('{s: '{2'd1, 20'h7FFFF, 20'h80000, 1'b0}, chk: 1'b0, exp: none});
        tbl.push_back('{s: '{2'd1, 20'h7FFFF, 20'h7FFFF, 1'b0}, chk: 1'b0, exp: none});
        tbl.push_back('{s: '{2'd1, 20'h7FFFF, 20'h00000, 1'b1}, chk: 1'b0, exp: none});
        tbl.push_back('{s: '{2'd1, 20'h80000, 20'h7FFFF, 1'b0}, chk: 1'b0, exp: none});
        tbl.push_back('{s: '{2'd2, 20'h80000, 20'h80000, 1'b1}, chk: 1'b0, exp: none});
        tbl.push_back('{s: '{2'd2, 20'h80000, 20'h80000, 1'b0}, chk: 1'b0, exp: none});
        tbl.push_back('{s: '{2'd0, 20'h7FFFF, 20'h12345, 1'b0}, chk: 1'b0, exp: none});
        tbl.push_back('{s: '{2'd0, 20'h7FFFF, 20'h12345, 1'b1}, chk: 1'b0, exp: none});
        tbl.push_back('{s: '{2'd0, 20'hFFFFF, 20'h00001, 1'b1}, chk: 1'b0, exp: none});
        tbl.push_back('{s: '{2'd2, 20'h00001, 20'hFFFFF, 1'b0}, chk: 1'b0, exp: none});
        foreach (tbl[k])
            send(tbl[k].s, tbl[k].exp, tbl[k].chk);
        wait_drained();

        // Extreme settings: all-ones registers and an oversized output limit, then all-zero registers.
        reg_write(REG_KP, '1);
        reg_write(REG_KI, '1);
        reg_write(REG_KD, '1);
        reg_write(REG_OLIM, '1);
        reg_write(REG_ILIM, '1);
        reg_write(REG_LP, '1);
        reg_write(REG_DTF, '1);
        for (i = 0; i < 30; i++) send(rnd_sample(), none, 1'b0);
        wait_drained();
        reg_write(REG_KP, '0);
        reg_write(REG_KI, '0);
        reg_write(REG_KD, '0);
        reg_write(REG_OLIM, '0);
        reg_write(REG_ILIM, '0);
        reg_write(REG_LP, '0);
        reg_write(REG_DTF, '0);
        for (i = 0; i < 20; i++) send(rnd_sample(), none, 1'b0);
        wait_drained();

        for (int ph = 0; ph < 3; ph++)
        begin
            src_gap = (ph == 0) ? 8 : (ph == 1) ? 53 : 0;
            snk_gap = (ph == 0) ? 53 : (ph == 1) ? 8 : 0;
            reg_write(REG_KP, 48'($urandom) | (48'($urandom) << 32));
            reg_write(REG_KI, 48'($urandom_range(65535)) * 48'h000100010001);
            reg_write(REG_KD, 48'($urandom) | (48'($urandom) << 32));
            reg_write(REG_OLIM, 48'($urandom_range(20000)) * 48'h000100010001);
            reg_write(REG_ILIM, 48'($urandom) | (48'($urandom) << 32));
            reg_write(REG_LP, 48'($urandom_range(16777215)));
            reg_write(REG_DTF, 48'($urandom_range(65535)));
            for (i = 0; i < RANDOM_WORDS / 3; i++)
            begin
                send(rnd_sample(), none, 1'b0);
                if (i == 100) wait_drained();
            end
            wait_drained();
        end

        if (mismatches == 0 && expected_drives.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule

>>> filelist.f
hw/rtl/pidac_pkg.sv
hw/rtl/pidac_if.sv
hw/rtl/pidac_ctrl.sv
hw/rtl/pidac_datapath.sv
hw/rtl/pid_axis_controller.sv
dv/tb_pid_axis_controller.sv
